/* src/c3f_pkg.sv */
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared widths, reset values and codes of the clamped 3x3 convolution core.
// ----------------------------------------------------------------------------
package c3f_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned SideW   = 10;
  localparam int unsigned KernW   = 24;
  localparam int unsigned PosW    = 19;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SumW    = 21;
  localparam int unsigned TotW    = SumW + 1;
  localparam int unsigned MagW    = 20;
  localparam int unsigned QuotW   = 16;

  // floor(x / 9) == (x * RecipNine) >> RecipShift for x < 2**MagW
  localparam int unsigned RecipW     = 21;
  localparam int unsigned RecipShift = 24;
  localparam logic [RecipW-1:0] RecipNine = 21'd1864136;

  localparam int unsigned SideReset = 400;
  localparam logic [KernW-1:0] KernTopReset = 24'h000000;
  localparam logic [KernW-1:0] KernMidReset = 24'h0001FF;
  localparam logic [KernW-1:0] KernBotReset = 24'h000000;

  localparam logic signed [TotW-1:0] PixMax = 255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SIDE = 2'd0,
    REG_KTOP = 2'd1,
    REG_KMID = 2'd2,
    REG_KBOT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } seq_state_e;

  // result and frame-last flags, then neighbor masks: top row, bottom row, left column, right column
  typedef struct packed {
    logic res;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } item_ctl_t;

endpackage

/* src/conv3x3_clamped_filter_core.sv */
// ----------------------------------------------------------------------------
// conv3x3_clamped_filter_core
// Streaming 3x3 convolution over a square 8-bit frame with zero borders,
// s + s/9 gain and clamping to 0..255.
// ----------------------------------------------------------------------------
// Takes one beat per clock on the input while the stages have room and no
// position rebuild runs, and gives at most one beat per clock on the output;
// two line memories of MAX_SIDE bytes each (no clearing pass; the lower one
// is read and written in the same cycle) and a 3x3 window feed a
// five-register path (line read, window, weighted sum, divide-by-nine
// product, clamp). Results trail the pixel stream by image_side + 1 beats;
// send image_side + 1 drain beats (cmd = 1) after the last pixel to flush the
// frame. Stalls on the output fill the internal stages before the input
// stalls. After a write of image_side the input takes no beats while an
// iterative divider rebuilds the row and column positions for the new side.
module conv3x3_clamped_filter_core
  import c3f_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [KernW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [PixW-1:0]    pixel_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PixW-1:0]    out_pixel_o,
  output logic               frame_last_o
);

  localparam int unsigned AW       = $clog2(MAX_SIDE);
  localparam int unsigned SideMaxW = (1 << SideW) - 1;
  localparam int unsigned SideCap  = (MAX_SIDE > SideMaxW) ? SideMaxW : MAX_SIDE;
  localparam int unsigned SideInit = (SideReset > SideCap) ? SideCap : SideReset;
  localparam int unsigned LastW    = 2 * SideW;
  localparam int unsigned LastInit = SideInit * SideInit - 1;
  localparam int unsigned DivCntW  = $clog2(PosW);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(PosW - 1);

  // configuration
  logic [SideW-1:0] side_q;
  logic [SideW-1:0] side_wr;
  logic [SideW-1:0] side_raw;
  logic [KernW-1:0] ktop_q, kmid_q, kbot_q;
  logic [LastW-1:0] last_pos_q;
  seq_state_e       state_q;

  // positions and divider
  logic [PosW-1:0]    n_q, p_q, row_q;
  logic [AW-1:0]      in_col_q, col_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [SideW-1:0]   rem_n_q, rem_p_q;
  logic [PosW-1:0]    dq_n_q, dq_p_q;
  logic [SideW:0]     tn, tp;
  logic               gn, gp;
  logic [SideW-1:0]   rn_nx, rp_nx;
  logic [PosW-1:0]    qn_nx, qp_nx;

  // stages
  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  item_ctl_t       s1_ctl_q, s2_ctl_q, in_ctl;
  logic [PixW-1:0] s1_x_q;
  logic [AW-1:0]   s1_addr_q;
  logic            s1_fwd_q;
  logic [PixW-1:0] lo_rd_q, up_rd_q, mid_prev_q;
  logic [PixW-1:0] win_q [9];
  logic            s3_last_q, s4_last_q, out_last_q;
  logic signed [SumW-1:0] s3_sum_q, s4_sum_q;
  logic [QuotW-1:0] s4_quot_q;
  logic [PixW-1:0]  out_pix_q;

  logic [PixW-1:0] lo_mem [MAX_SIDE];
  logic [PixW-1:0] up_mem [MAX_SIDE];

  // handshake chain
  logic out_free, s4_free, s3_free, s2_free, s1_free, s1_move, accept;

  assign out_free   = !out_v_q || out_ready_i;
  assign s4_free    = !s4_v_q || out_free;
  assign s3_free    = !s3_v_q || s4_free;
  assign s2_free    = !s2_v_q || s3_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign s1_move    = s1_v_q && s2_free;
  assign in_ready_o = s1_free && (state_q == ST_RUN);
  assign accept     = in_valid_i && in_ready_o;

  // position bookkeeping for the accepted beat
  logic [PosW-1:0] s_pos;
  logic            produce, is_last, n_wrap, p_wrap, col_end;
  logic [AW-1:0]   in_col_nx;
  logic [PixW-1:0] x_in;
  logic [PixW-1:0] mid_in, top_in;

  always_comb begin
    s_pos     = PosW'(side_q);
    produce   = n_q > s_pos;
    is_last   = LastW'(p_q) >= last_pos_q;
    n_wrap    = &n_q;
    p_wrap    = &p_q;
    col_end   = (PosW'(col_q) + PosW'(1)) == s_pos;
    in_col_nx = (n_wrap || ((PosW'(in_col_q) + PosW'(1)) == s_pos)) ? '0
                : in_col_q + AW'(1);
    x_in      = cmd_i ? '0 : pixel_value_i;
    in_ctl.res      = produce;
    in_ctl.last     = produce && is_last;
    in_ctl.top_ok   = row_q != '0;
    in_ctl.bot_ok   = row_q < (s_pos - PosW'(1));
    in_ctl.left_ok  = col_q != '0;
    in_ctl.right_ok = PosW'(col_q) < (s_pos - PosW'(1));
    mid_in = lo_rd_q;
    top_in = s1_fwd_q ? mid_prev_q : up_rd_q;
  end

  // side clamp on write
  always_comb begin
    side_raw = cfg_data_i[SideW-1:0];
    side_wr  = side_raw;
    if (side_raw == '0) begin
      side_wr = SideW'(1);
    end else if (32'(side_raw) > SideCap) begin
      side_wr = SideW'(SideCap);
    end
  end

  // one restoring divide step for n and p
  always_comb begin
    tn    = {rem_n_q, dq_n_q[PosW-1]};
    tp    = {rem_p_q, dq_p_q[PosW-1]};
    gn    = tn >= {1'b0, side_q};
    gp    = tp >= {1'b0, side_q};
    rn_nx = SideW'(gn ? tn - {1'b0, side_q} : tn);
    rp_nx = SideW'(gp ? tp - {1'b0, side_q} : tp);
    qn_nx = {dq_n_q[PosW-2:0], gn};
    qp_nx = {dq_p_q[PosW-2:0], gp};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= SideW'(SideInit);
      ktop_q     <= KernTopReset;
      kmid_q     <= KernMidReset;
      kbot_q     <= KernBotReset;
      last_pos_q <= LastW'(LastInit);
      state_q    <= ST_RUN;
      div_cnt_q  <= '0;
      n_q        <= '0;
      p_q        <= '0;
      row_q      <= '0;
      in_col_q   <= '0;
      col_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SIDE: side_q <= side_wr;
          REG_KTOP: ktop_q <= cfg_data_i;
          REG_KMID: kmid_q <= cfg_data_i;
          REG_KBOT: kbot_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_SIDE)) begin
        state_q   <= ST_DIV;
        div_cnt_q <= '0;
      end else begin
        case (state_q)
          ST_RUN: begin
            if (accept) begin
              if (produce && is_last) begin
                n_q      <= '0;
                p_q      <= '0;
                row_q    <= '0;
                in_col_q <= '0;
                col_q    <= '0;
              end else begin
                n_q      <= n_q + PosW'(1);
                in_col_q <= in_col_nx;
                if (produce) begin
                  p_q <= p_q + PosW'(1);
                  if (p_wrap) begin
                    row_q <= '0;
                    col_q <= '0;
                  end else if (col_end) begin
                    row_q <= row_q + PosW'(1);
                    col_q <= '0;
                  end else begin
                    col_q <= col_q + AW'(1);
                  end
                end
              end
            end
          end
          ST_DIV: begin
            last_pos_q <= LastW'(side_q) * LastW'(side_q) - LastW'(1);
            if (div_cnt_q == DivLast) begin
              in_col_q <= AW'(rn_nx);
              row_q    <= qp_nx;
              col_q    <= AW'(rp_nx);
              state_q  <= ST_RUN;
            end else begin
              div_cnt_q <= div_cnt_q + DivCntW'(1);
            end
          end
          default: state_q <= ST_RUN;
        endcase
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_SIDE)) begin
      rem_n_q <= '0;
      rem_p_q <= '0;
      dq_n_q  <= n_q;
      dq_p_q  <= p_q;
    end else if (state_q == ST_DIV) begin
      rem_n_q <= rn_nx;
      rem_p_q <= rp_nx;
      dq_n_q  <= qn_nx;
      dq_p_q  <= qp_nx;
    end
  end

  // line memories
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_mem[in_col_q] <= x_in;
      lo_rd_q          <= lo_mem[in_col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      up_mem[s1_addr_q] <= mid_in;
    end
    if (accept) begin
      up_rd_q <= up_mem[in_col_q];
    end
  end

  // weighted sum over the masked window
  logic [KernW-1:0] krow [3];
  logic             row_ok [3];
  logic             col_ok [3];
  logic signed [SumW-1:0] acc;
  logic signed [SumW-1:0] pterm;

  always_comb begin
    krow[0]   = ktop_q;
    krow[1]   = kmid_q;
    krow[2]   = kbot_q;
    row_ok[0] = s2_ctl_q.top_ok;
    row_ok[1] = 1'b1;
    row_ok[2] = s2_ctl_q.bot_ok;
    col_ok[0] = s2_ctl_q.left_ok;
    col_ok[1] = 1'b1;
    col_ok[2] = s2_ctl_q.right_ok;
    acc       = '0;
    pterm     = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pterm = SumW'($signed({1'b0, win_q[3*r+c]}))
              * SumW'($signed(krow[r][PixW*c +: PixW]));
        if (row_ok[r] && col_ok[c]) begin
          acc = acc + pterm;
        end
      end
    end
  end

  // divide by nine and clamp
  logic [MagW-1:0]        mag;
  logic [MagW+RecipW-1:0] qprod;
  logic signed [TotW-1:0] qs, tot;
  logic [PixW-1:0]        clamped;

  always_comb begin
    mag   = MagW'(s3_sum_q[SumW-1] ? -s3_sum_q : s3_sum_q);
    qprod = (MagW+RecipW)'(mag) * (MagW+RecipW)'(RecipNine);
    qs    = TotW'($signed({1'b0, s4_quot_q}));
    tot   = TotW'(s4_sum_q) + (s4_sum_q[SumW-1] ? -qs : qs);
    if (tot < 0) begin
      clamped = '0;
    end else if (tot > PixMax) begin
      clamped = PixW'(PixMax);
    end else begin
      clamped = tot[PixW-1:0];
    end
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end

      if (s1_move) begin
        s2_v_q   <= s1_ctl_q.res;
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= top_in;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= mid_in;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= s1_x_q;
      end else if (s2_v_q && s3_free) begin
        s2_v_q <= 1'b0;
      end

      if (s2_v_q && s3_free) begin
        s3_v_q <= 1'b1;
      end else if (s3_v_q && s4_free) begin
        s3_v_q <= 1'b0;
      end

      if (s3_v_q && s4_free) begin
        s4_v_q <= 1'b1;
      end else if (s4_v_q && out_free) begin
        s4_v_q <= 1'b0;
      end

      if (s4_v_q && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q  <= in_ctl;
      s1_x_q    <= x_in;
      s1_addr_q <= in_col_q;
      s1_fwd_q  <= s1_move && (s1_addr_q == in_col_q);
    end
    if (s1_move) begin
      s2_ctl_q   <= s1_ctl_q;
      mid_prev_q <= mid_in;
    end
    if (s2_v_q && s3_free) begin
      s3_sum_q  <= acc;
      s3_last_q <= s2_ctl_q.last;
    end
    if (s3_v_q && s4_free) begin
      s4_sum_q  <= s3_sum_q;
      s4_quot_q <= QuotW'(qprod >> RecipShift);
      s4_last_q <= s3_last_q;
    end
    if (s4_v_q && out_free) begin
      out_pix_q  <= clamped;
      out_last_q <= s4_last_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_pixel_o  = out_pix_q;
  assign frame_last_o = out_last_q;

`ifndef NO_ASSERTIONS
  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (PosW'(in_col_q) < s_pos))
    else $error("line column outside frame side");

  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (PosW'(col_q) < s_pos))
    else $error("output column outside frame side");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && produce && is_last && !cfg_we_i)
      |=> (n_q == '0 && p_q == '0 && row_q == '0 && col_q == '0))
    else $error("positions not cleared after last beat of frame");

  a_div_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_reg_e'(cfg_idx_i) == REG_SIDE) |=> !in_ready_o)
    else $error("input open while positions are rebuilt");
`endif

endmodule
